@@ rtl/dtq_pkg.sv @@
// Shared types and constants for the deadline timer queue.
`default_nettype none

package dtq_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  timer_id;
    logic [63:0] delay;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        fired;
    logic [3:0]  fired_id;
    logic [63:0] wait_ns;
  } out_item_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [3:0]  owner;
  } entry_t;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] res;
    logic        cout;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/dtq_alu.sv @@
// Shared 64-bit adder and subtractor with carry out used for all deadline arithmetic.
`default_nettype none

module dtq_alu (
  input  wire dtq_pkg::alu_req_t req,
  output dtq_pkg::alu_rsp_t      rsp
);
  import dtq_pkg::*;

  logic        sub;
  logic [63:0] b_op;
  logic [64:0] sum;

  // For a subtract the carry out is set exactly when a >= b.
  always_comb begin
    sub      = (req.op == ALU_SUB);
    b_op     = sub ? ~req.b : req.b;
    sum      = {1'b0, req.a} + {1'b0, b_op} + {64'd0, sub};
    rsp.res  = sum[63:0];
    rsp.cout = sum[64];
  end

endmodule

`default_nettype wire

@@ rtl/dtq_ctrl.sv @@
// Sequencer that keeps the sorted deadline memory, armed flags and item count.
`default_nettype none

module dtq_ctrl #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire dtq_pkg::in_item_t  in_data,
  output logic                    res_valid,
  input  wire                     res_take,
  output dtq_pkg::out_item_t      res_data,
  output dtq_pkg::alu_req_t       alu_req,
  input  wire dtq_pkg::alu_rsp_t  alu_rsp
);
  import dtq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_ADD      = 12'b000000000010,
    S_INS_RD   = 12'b000000000100,
    S_INS_CMP  = 12'b000000001000,
    S_REM_RD   = 12'b000000010000,
    S_REM_CHK  = 12'b000000100000,
    S_CHK_RD   = 12'b000001000000,
    S_CHK_CMP  = 12'b000010000000,
    S_CHK_WAIT = 12'b000100000000,
    S_SHD_RD   = 12'b001000000000,
    S_SHD_WR   = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  out_item_t       res_r, res_nxt;
  logic [63:0]     dl_r, dl_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SLOTS-1:0] armed_r, armed_nxt;

  entry_t          mem [SLOTS];
  entry_t          rd_data_r;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  entry_t          mem_wd;

  logic            in_id_ok;
  logic            in_armed;
  logic            own_ok;
  logic [CW-1:0]   pos_dec;
  logic [CW-1:0]   pos_inc;

  always_comb begin
    in_id_ok = (32'(in_data.timer_id) < SLOTS);
    in_armed = armed_r[IW'(in_data.timer_id)];
    own_ok   = (32'(rd_data_r.owner) < SLOTS);
    pos_dec  = pos_r - ONE_C;
    pos_inc  = pos_r + ONE_C;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    dl_nxt    = dl_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    armed_nxt = armed_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = pos_r[IW-1:0];
    mem_we    = 1'b0;
    mem_wa    = pos_r[IW-1:0];
    mem_wd    = rd_data_r;
    alu_req.op = ALU_ADD;
    alu_req.a  = item_r.now;
    alu_req.b  = item_r.delay;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          pos_nxt  = '0;
          state_nxt = S_DONE;
          unique case (in_data.mode)
            MODE_ADD: begin
              if (in_id_ok && !in_armed && (count_r < SLOTS_C)) begin
                state_nxt = S_ADD;
              end
            end
            MODE_REMOVE: begin
              if (in_id_ok && in_armed) begin
                state_nxt = S_REM_RD;
              end
            end
            MODE_CHECK: begin
              if (count_r != '0) begin
                state_nxt = S_CHK_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ADD: begin
        // Deadline saturates at the all-ones value on overflow.
        alu_req.op = ALU_ADD;
        alu_req.a  = item_r.now;
        alu_req.b  = item_r.delay;
        dl_nxt     = alu_rsp.cout ? '1 : alu_rsp.res;
        pos_nxt    = count_r;
        state_nxt  = S_INS_RD;
      end

      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          mem_wd    = '{deadline: dl_r, owner: item_r.timer_id};
          count_nxt = count_r + ONE_C;
          armed_nxt[IW'(item_r.timer_id)] = 1'b1;
          res_nxt.accepted = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pos_dec[IW-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        // Walk from the tail; an entry moves up only if its deadline is later,
        // so equal deadlines keep their arrival order.
        alu_req.op = ALU_SUB;
        alu_req.a  = dl_r;
        alu_req.b  = rd_data_r.deadline;
        mem_we     = 1'b1;
        if (alu_rsp.cout) begin
          mem_wd    = '{deadline: dl_r, owner: item_r.timer_id};
          count_nxt = count_r + ONE_C;
          armed_nxt[IW'(item_r.timer_id)] = 1'b1;
          res_nxt.accepted = 1'b1;
          state_nxt = S_DONE;
        end else begin
          mem_wd    = rd_data_r;
          pos_nxt   = pos_dec;
          state_nxt = S_INS_RD;
        end
      end

      S_REM_RD: begin
        if (pos_r >= count_r) begin
          armed_nxt[IW'(item_r.timer_id)] = 1'b0;
          res_nxt.accepted = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = pos_r[IW-1:0];
          state_nxt = S_REM_CHK;
        end
      end

      S_REM_CHK: begin
        if (rd_data_r.owner == item_r.timer_id) begin
          armed_nxt[IW'(item_r.timer_id)] = 1'b0;
          res_nxt.accepted = 1'b1;
          state_nxt = S_SHD_RD;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_REM_RD;
        end
      end

      S_CHK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_CHK_CMP;
      end

      S_CHK_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = item_r.now;
        alu_req.b  = rd_data_r.deadline;
        if (alu_rsp.cout) begin
          res_nxt.fired    = 1'b1;
          res_nxt.fired_id = rd_data_r.owner;
          if (own_ok) begin
            armed_nxt[IW'(rd_data_r.owner)] = 1'b0;
          end
          pos_nxt   = '0;
          state_nxt = S_SHD_RD;
        end else begin
          state_nxt = S_CHK_WAIT;
        end
      end

      S_CHK_WAIT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = rd_data_r.deadline;
        alu_req.b  = item_r.now;
        res_nxt.wait_ns = alu_rsp.res;
        state_nxt = S_DONE;
      end

      S_SHD_RD: begin
        // Close the gap at pos_r by moving every later entry down by one.
        if (pos_inc < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = pos_inc[IW-1:0];
          state_nxt = S_SHD_WR;
        end else begin
          count_nxt = count_r - ONE_C;
          state_nxt = S_DONE;
        end
      end

      S_SHD_WR: begin
        mem_we    = 1'b1;
        mem_wd    = rd_data_r;
        pos_nxt   = pos_inc;
        state_nxt = S_SHD_RD;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      armed_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    dl_r   <= dl_nxt;
    pos_r  <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/deadline_timer_queue_unit.sv @@
// Top level of the deadline timer queue: sequencer, shared adder and result register.
//
//   channel   direction  payload                 transfer when
//   in_       input      dtq_pkg::in_item_t      in_valid && in_ready
//   out_      output     dtq_pkg::out_item_t     out_valid && out_ready
//
// One item at a time. The queue lives in a single-port-per-cycle memory, so each
// entry touched costs a read step, then a compare or write step. An add walks
// from the tail past entries with later deadlines; a remove scans from the head
// for its timer, an expiring check takes the head, and both then shift the later
// entries down; a non-expiring check reports the wait; an ignored item goes straight
// to the result. A stalled output holds the sequencer until the result moves on.
// Synchronous active-low reset empties the queue and clears all armed flags.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module deadline_timer_queue_unit #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire dtq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output dtq_pkg::out_item_t      out_data
);
  import dtq_pkg::*;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  logic      res_valid;
  logic      res_take;
  out_item_t res_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  dtq_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_take (res_take),
    .res_data (res_data),
    .alu_req  (alu_req),
    .alu_rsp  (alu_rsp)
  );

  dtq_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_comb begin
    res_take      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
